// ===== hw/rtl/acde_pkg.sv =====
// Package for the audio clock drift estimator: beat payload types, sequencer
// states and arithmetic constants. Depends on nothing; used by the top level.
package acde_pkg;

    // Item kinds carried by an input beat.
    localparam logic [1:0] KIND_SENT   = 2'd0;
    localparam logic [1:0] KIND_FORMAT = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    // Defaults and scale factors.
    localparam logic [19:0] DEFAULT_RATE   = 20'd44100;
    localparam int          NOM_SCALE      = 1000;
    localparam logic [63:0] MIN_ELAPSED_US = 64'd1000000;

    // Constant multipliers walked bit by bit through the shared adder.
    localparam int          MULT_W     = 30;
    localparam logic [MULT_W-1:0] MUL1_CONST = 30'd1000000000;
    localparam logic [MULT_W-1:0] MUL2_CONST = 30'd1000000;

    // Restoring division: one quotient bit per step.
    localparam int DIV_STEPS = 64;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Input beat.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] byte_count;
        logic [62:0] now_us;
        logic [19:0] rate_hz;
        logic [5:0]  sample_bits;
        logic        stereo;
    } in_t;

    // Result beat.
    typedef struct packed {
        logic [63:0]        frame_total;
        logic signed [31:0] drift_ppm;
    } out_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD,
        S_ELAP,
        S_DF,
        S_MUL1,
        S_NEG1,
        S_DIV1,
        S_FIX1,
        S_SUB,
        S_MUL2,
        S_NEG2,
        S_DIV2,
        S_FIX2,
        S_DONE
    } state_t;

endpackage

// ===== hw/rtl/audio_clock_drift_estimator_unit.sv =====
// Top level of the audio clock drift estimator. Depends on acde_pkg.
// A drift estimate is computed unless there is no anchor, time went back, or under one
// second has elapsed. A new beat is taken only after the last result beat is loaded; the
// work per beat is set by two 64-step restoring divisions and two shift-and-add
// multiplies on one shared 64-bit adder.
// Synchronous reset (aresetn low) clears frames and anchor, 44100 Hz, 4 bytes per frame.
module audio_clock_drift_estimator_unit (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  acde_pkg::in_t  s_payload,
    output logic           m_valid,
    input  logic           m_ready,
    output acde_pkg::out_t m_payload
);

    // Sequencer and architectural state.
    acde_pkg::state_t state_reg, state_next;
    logic [63:0] frame_count_reg, frame_count_next;
    logic        anchor_valid_reg, anchor_valid_next;
    logic [63:0] anchor_frame_reg, anchor_frame_next;
    logic [62:0] anchor_time_reg, anchor_time_next;
    logic [19:0] nominal_rate_reg, nominal_rate_next;
    logic [3:0]  frame_bytes_reg, frame_bytes_next;

    // Datapath registers.
    acde_pkg::in_t item_reg, item_next;
    logic [29:0] nom_reg, nom_next;
    logic [63:0] den_reg, den_next;
    logic [63:0] mcand_reg, mcand_next;
    logic [63:0] acc_reg, acc_next;
    logic [acde_pkg::MULT_W-1:0] mult_reg, mult_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic        neg_reg, neg_next;
    logic [acde_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0] ppm_reg, ppm_next;
    logic        m_valid_reg, m_valid_next;
    acde_pkg::out_t m_payload_reg, m_payload_next;

    // Shared adder/subtractor.
    logic [63:0] alu_a, alu_b;
    logic        alu_sub;
    logic [64:0] alu_sum;
    logic [63:0] trial;
    logic [15:0] frames_sent;

    assign s_ready   = (state_reg == acde_pkg::S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Frames in the byte count: divide by 2, 4 or 8 as a shift.
    always_comb begin
        unique case (frame_bytes_reg)
            4'd2:    frames_sent = item_reg.byte_count >> 1;
            4'd8:    frames_sent = item_reg.byte_count >> 3;
            default: frames_sent = item_reg.byte_count >> 2;
        endcase
    end

    // Division trial value: remainder shifted left with the next dividend bit.
    assign trial = {rem_reg[62:0], quo_reg[63]};

    // Operand selection for the shared adder.
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            acde_pkg::S_UPD: begin
                alu_a = frame_count_reg;
                alu_b = 64'(frames_sent);
            end
            acde_pkg::S_ELAP: begin
                alu_a   = {1'b0, item_reg.now_us};
                alu_b   = {1'b0, anchor_time_reg};
                alu_sub = 1'b1;
            end
            acde_pkg::S_DF: begin
                alu_a   = frame_count_reg;
                alu_b   = anchor_frame_reg;
                alu_sub = 1'b1;
            end
            acde_pkg::S_MUL1, acde_pkg::S_MUL2: begin
                alu_a = acc_reg;
                alu_b = mcand_reg;
            end
            acde_pkg::S_NEG1, acde_pkg::S_NEG2: begin
                alu_b   = acc_reg;
                alu_sub = 1'b1;
            end
            acde_pkg::S_DIV1, acde_pkg::S_DIV2: begin
                alu_a   = trial;
                alu_b   = den_reg;
                alu_sub = 1'b1;
            end
            acde_pkg::S_FIX1, acde_pkg::S_FIX2: begin
                alu_b   = quo_reg;
                alu_sub = 1'b1;
            end
            acde_pkg::S_SUB: begin
                alu_a   = quo_reg;
                alu_b   = 64'(nom_reg);
                alu_sub = 1'b1;
            end
            default: begin
                alu_sub = 1'b0;
            end
        endcase
    end

    // A set carry out on a subtraction means no borrow.
    assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {64{alu_sub}}} + 65'(alu_sub);

    // Sequencer: next state and datapath updates.
    always_comb begin
        state_next        = state_reg;
        frame_count_next  = frame_count_reg;
        anchor_valid_next = anchor_valid_reg;
        anchor_frame_next = anchor_frame_reg;
        anchor_time_next  = anchor_time_reg;
        nominal_rate_next = nominal_rate_reg;
        frame_bytes_next  = frame_bytes_reg;
        item_next         = item_reg;
        nom_next          = nom_reg;
        den_next          = den_reg;
        mcand_next        = mcand_reg;
        acc_next          = acc_reg;
        mult_next         = mult_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        neg_next          = neg_reg;
        cnt_next          = cnt_reg;
        ppm_next          = ppm_reg;
        m_valid_next      = m_valid_reg;
        m_payload_next    = m_payload_reg;

        // The waiting result leaves when the downstream side takes it.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            acde_pkg::S_IDLE: begin
                if (s_valid) begin
                    item_next  = s_payload;
                    state_next = acde_pkg::S_UPD;
                end
            end
            acde_pkg::S_UPD: begin
                unique case (item_reg.kind)
                    acde_pkg::KIND_SENT: begin
                        frame_count_next = alu_sum[63:0];
                        if (!anchor_valid_reg) begin
                            anchor_valid_next = 1'b1;
                            anchor_frame_next = alu_sum[63:0];
                            anchor_time_next  = item_reg.now_us;
                        end
                    end
                    acde_pkg::KIND_FORMAT: begin
                        nominal_rate_next = (item_reg.rate_hz != '0) ? item_reg.rate_hz
                                                                      : acde_pkg::DEFAULT_RATE;
                        frame_bytes_next  = ((item_reg.sample_bits >= 6'd32) ? 4'd4 : 4'd2)
                                            << item_reg.stereo;
                        anchor_valid_next = 1'b1;
                        anchor_frame_next = frame_count_reg;
                        anchor_time_next  = item_reg.now_us;
                    end
                    default: begin
                        // Queries and the unused kind leave the state alone.
                        anchor_valid_next = anchor_valid_reg;
                    end
                endcase
                state_next = acde_pkg::S_ELAP;
            end
            acde_pkg::S_ELAP: begin
                den_next   = alu_sum[63:0];
                nom_next   = 30'(nominal_rate_reg) * 30'(acde_pkg::NOM_SCALE);
                state_next = acde_pkg::S_DF;
            end
            acde_pkg::S_DF: begin
                mcand_next = alu_sum[63:0];
                acc_next   = '0;
                mult_next  = acde_pkg::MUL1_CONST;
                // No estimate without an anchor, with time going back, or too soon.
                if (!anchor_valid_reg || den_reg[63] || den_reg < acde_pkg::MIN_ELAPSED_US) begin
                    ppm_next   = '0;
                    state_next = acde_pkg::S_DONE;
                end else begin
                    state_next = acde_pkg::S_MUL1;
                end
            end
            acde_pkg::S_MUL1, acde_pkg::S_MUL2: begin
                if (mult_reg[0]) begin
                    acc_next = alu_sum[63:0];
                end
                mcand_next = mcand_reg << 1;
                mult_next  = mult_reg >> 1;
                if (mult_reg[acde_pkg::MULT_W-1:1] == '0) begin
                    state_next = (state_reg == acde_pkg::S_MUL1) ? acde_pkg::S_NEG1
                                                                 : acde_pkg::S_NEG2;
                end
            end
            acde_pkg::S_NEG1, acde_pkg::S_NEG2: begin
                neg_next = acc_reg[63];
                quo_next = acc_reg[63] ? alu_sum[63:0] : acc_reg;
                rem_next = '0;
                cnt_next = '0;
                if (state_reg == acde_pkg::S_NEG1) begin
                    state_next = acde_pkg::S_DIV1;
                end else begin
                    den_next   = 64'(nom_reg);
                    state_next = acde_pkg::S_DIV2;
                end
            end
            acde_pkg::S_DIV1, acde_pkg::S_DIV2: begin
                if (alu_sum[64]) begin
                    rem_next = alu_sum[63:0];
                    quo_next = {quo_reg[62:0], 1'b1};
                end else begin
                    rem_next = trial;
                    quo_next = {quo_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == acde_pkg::CNT_W'(acde_pkg::DIV_STEPS - 1)) begin
                    state_next = (state_reg == acde_pkg::S_DIV1) ? acde_pkg::S_FIX1
                                                                 : acde_pkg::S_FIX2;
                end
            end
            acde_pkg::S_FIX1: begin
                if (neg_reg) begin
                    quo_next = alu_sum[63:0];
                end
                state_next = acde_pkg::S_SUB;
            end
            acde_pkg::S_SUB: begin
                mcand_next = alu_sum[63:0];
                acc_next   = '0;
                mult_next  = acde_pkg::MUL2_CONST;
                state_next = acde_pkg::S_MUL2;
            end
            acde_pkg::S_FIX2: begin
                ppm_next   = neg_reg ? alu_sum[31:0] : quo_reg[31:0];
                state_next = acde_pkg::S_DONE;
            end
            acde_pkg::S_DONE: begin
                // Load the result register once it is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                 = 1'b1;
                    m_payload_next.frame_total   = frame_count_reg;
                    m_payload_next.drift_ppm     = ppm_reg;
                    state_next                   = acde_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = acde_pkg::S_IDLE;
            end
        endcase
    end

    // Control and architectural state, cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= acde_pkg::S_IDLE;
            m_valid_reg      <= 1'b0;
            frame_count_reg  <= '0;
            anchor_valid_reg <= 1'b0;
            anchor_frame_reg <= '0;
            anchor_time_reg  <= '0;
            nominal_rate_reg <= acde_pkg::DEFAULT_RATE;
            frame_bytes_reg  <= 4'd4;
        end else begin
            state_reg        <= state_next;
            m_valid_reg      <= m_valid_next;
            frame_count_reg  <= frame_count_next;
            anchor_valid_reg <= anchor_valid_next;
            anchor_frame_reg <= anchor_frame_next;
            anchor_time_reg  <= anchor_time_next;
            nominal_rate_reg <= nominal_rate_next;
            frame_bytes_reg  <= frame_bytes_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge aclk) begin
        item_reg      <= item_next;
        nom_reg       <= nom_next;
        den_reg       <= den_next;
        mcand_reg     <= mcand_next;
        acc_reg       <= acc_next;
        mult_reg      <= mult_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        neg_reg       <= neg_next;
        cnt_reg       <= cnt_next;
        ppm_reg       <= ppm_next;
        m_payload_reg <= m_payload_next;
    end

    // An accepted beat makes the block busy on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while the block stays ready");

    // The divisor is never zero while dividing.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == acde_pkg::S_DIV1 || state_reg == acde_pkg::S_DIV2) |-> (den_reg != '0))
        else $error("division by zero in the shared unit");

    // The partial remainder stays below the divisor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == acde_pkg::S_DIV1 || state_reg == acde_pkg::S_DIV2) |-> (rem_reg < den_reg))
        else $error("division remainder out of range");

    // Bytes per frame is always 2, 4 or 8.
    assert property (@(posedge aclk) disable iff (!aresetn)
        frame_bytes_reg == 4'd2 || frame_bytes_reg == 4'd4 || frame_bytes_reg == 4'd8)
        else $error("bytes per frame out of range");

endmodule
